// ===== hdl/cpll_pkg.sv =====
`timescale 1ns / 1ps
package cpll_pkg;
   localparam int Capacity  = 256;
   localparam int DataWidth = 32;
   localparam int SlotBits  = $clog2(Capacity);
   localparam int LinkBits  = SlotBits + 1;
   localparam logic [LinkBits-1:0] NoneLink = LinkBits'(Capacity);

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_READ   = 3'd3,
      OP_HEAD   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef struct packed {
      logic                  we;
      logic [SlotBits-1:0]   waddr;
      logic [LinkBits-1:0]   wprev;
      logic [LinkBits-1:0]   wnext;
      logic [DataWidth-1:0]  wdata;
      logic                  wprev_en;
      logic                  wnext_en;
      logic                  wdata_en;
      logic [SlotBits-1:0]   raddr;
   } mem_cmd_type;

   typedef struct packed {
      logic [LinkBits-1:0]  prev;
      logic [LinkBits-1:0]  next;
      logic [DataWidth-1:0] data;
   } mem_rsp_type;
endpackage

// ===== hdl/cpll_req_if.sv =====
`timescale 1ns / 1ps
interface cpll_req_if;
   logic                            valid;
   logic                            ready;
   logic [2:0]                      operation;
   logic [cpll_pkg::SlotBits-1:0]   slot;
   logic [cpll_pkg::DataWidth-1:0]  data;
   modport source (output valid, operation, slot, data, input ready);
   modport sink (input valid, operation, slot, data, output ready);
endinterface

// ===== hdl/cpll_rsp_if.sv =====
`timescale 1ns / 1ps
interface cpll_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic [cpll_pkg::LinkBits-1:0]   result_slot;
   logic [cpll_pkg::DataWidth-1:0]  data_out;
   logic [cpll_pkg::LinkBits-1:0]   prev_slot;
   logic [cpll_pkg::LinkBits-1:0]   next_slot;
   logic [cpll_pkg::LinkBits-1:0]   count;
   modport source (output valid, status, result_slot, data_out, prev_slot, next_slot, count,
                   input ready);
   modport sink (input valid, status, result_slot, data_out, prev_slot, next_slot, count,
                 output ready);
endinterface

// ===== hdl/cpll_csr_if.sv =====
`timescale 1ns / 1ps
interface cpll_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cpll_pkg::LinkBits-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hdl/compact_pool_linked_list.sv =====
`timescale 1ns / 1ps
// Request to response: head, clear, errors and append to an empty list go from decode
// straight to output; append to a non-empty list also links the old tail; read waits
// for memory data; insert and remove relink; remove refills a slot that was not last.
// Throughput: one transaction at a time, the next request is taken the cycle after
// the response; the node memory does one read and at most one write per cycle.
// Reset: synchronous, clears head, tail, count, limit to 256; memory not cleared.
module compact_pool_linked_list (
   input logic     clock,
   input logic     reset,
   cpll_req_if.sink   req,
   cpll_rsp_if.source rsp,
   cpll_csr_if.sink   csr
);
   localparam int SB = cpll_pkg::SlotBits;
   localparam int LB = cpll_pkg::LinkBits;
   localparam int DW = cpll_pkg::DataWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_INS_RD, S_INS_W1, S_INS_W2, S_INS_W3,
      S_RD_WAIT, S_RM_RD, S_RM_LRD, S_RM_LWAIT, S_RM_W1, S_RM_W2,
      S_RM_W3, S_RM_W4, S_RM_W5, S_OUT
   } state_type;

   state_type             state_ff;
   logic [2:0]            op_ff;
   logic [SB-1:0]         slot_ff;
   logic [DW-1:0]         data_ff;
   logic [LB-1:0]         head_ff, tail_ff, count_ff, limit_ff;
   logic [LB-1:0]         p_ff, n_ff, mp_ff, mn_ff, succ_ff;
   logic [DW-1:0]         md_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            status_ff;
   logic [LB-1:0]         res_ff, pout_ff, nout_ff;
   logic [DW-1:0]         dout_ff;
   cpll_pkg::mem_cmd_type cmd;
   cpll_pkg::mem_rsp_type mrsp;
   logic [LB-1:0]         usable, last;
   logic [SB-1:0]         last_a;
   logic                  occupied;

   cpll_node_mem u_mem (.clock(clock), .cmd(cmd), .rsp(mrsp));

   assign usable   = (limit_ff > cpll_pkg::NoneLink) ? cpll_pkg::NoneLink : limit_ff;
   assign last     = count_ff - LB'(1);
   assign last_a   = last[SB-1:0];
   assign occupied = {1'b0, slot_ff} < count_ff;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.result_slot = res_ff;
   assign rsp.data_out = dout_ff;
   assign rsp.prev_slot = pout_ff;
   assign rsp.next_slot = nout_ff;
   assign rsp.count = count_ff;

   always_comb begin
      cmd = '0;
      cmd.raddr = slot_ff;
      unique case (state_ff)
         S_DEC: begin
            if (op_ff == cpll_pkg::OP_APPEND && count_ff < usable) begin
               cmd.we = 1'b1; cmd.waddr = count_ff[SB-1:0];
               cmd.wprev = tail_ff; cmd.wnext = cpll_pkg::NoneLink; cmd.wdata = data_ff;
               cmd.wprev_en = 1'b1; cmd.wnext_en = 1'b1; cmd.wdata_en = 1'b1;
            end
         end
         S_INS_W1: begin
            cmd.we = 1'b1; cmd.waddr = count_ff[SB-1:0];
            cmd.wprev = {1'b0, slot_ff}; cmd.wnext = n_ff; cmd.wdata = data_ff;
            cmd.wprev_en = 1'b1; cmd.wnext_en = 1'b1; cmd.wdata_en = 1'b1;
         end
         S_INS_W2: begin
            cmd.we = (n_ff != cpll_pkg::NoneLink); cmd.waddr = n_ff[SB-1:0];
            cmd.wprev = count_ff; cmd.wprev_en = 1'b1;
         end
         S_INS_W3: begin
            cmd.we = 1'b1; cmd.waddr = slot_ff; cmd.wnext = count_ff; cmd.wnext_en = 1'b1;
         end
         S_RM_LRD: cmd.raddr = last_a;
         S_RM_W1: begin
            cmd.we = (p_ff != cpll_pkg::NoneLink); cmd.waddr = p_ff[SB-1:0];
            cmd.wnext = n_ff; cmd.wnext_en = 1'b1;
         end
         S_RM_W2: begin
            cmd.we = (n_ff != cpll_pkg::NoneLink); cmd.waddr = n_ff[SB-1:0];
            cmd.wprev = p_ff; cmd.wprev_en = 1'b1;
         end
         S_RM_W3: begin
            cmd.we = 1'b1; cmd.waddr = slot_ff;
            cmd.wprev = mp_ff; cmd.wnext = mn_ff; cmd.wdata = md_ff;
            cmd.wprev_en = 1'b1; cmd.wnext_en = 1'b1; cmd.wdata_en = 1'b1;
         end
         S_RM_W4: begin
            cmd.we = (mp_ff != cpll_pkg::NoneLink); cmd.waddr = mp_ff[SB-1:0];
            cmd.wnext = {1'b0, slot_ff}; cmd.wnext_en = 1'b1;
         end
         S_RM_W5: begin
            cmd.we = (mn_ff != cpll_pkg::NoneLink); cmd.waddr = mn_ff[SB-1:0];
            cmd.wprev = {1'b0, slot_ff}; cmd.wprev_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff <= cpll_pkg::NoneLink;
         tail_ff <= cpll_pkg::NoneLink;
         count_ff <= '0;
         limit_ff <= cpll_pkg::NoneLink;
      end else begin
         if (csr.valid) begin
            limit_ff <= csr.data;
         end
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  op_ff <= req.operation; slot_ff <= req.slot; data_ff <= req.data;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               status_ff <= cpll_pkg::ST_OK; res_ff <= cpll_pkg::NoneLink;
               dout_ff <= '0; pout_ff <= cpll_pkg::NoneLink; nout_ff <= cpll_pkg::NoneLink;
               state_ff <= S_OUT;
               priority case (op_ff)
                  cpll_pkg::OP_APPEND: begin
                     if (count_ff >= usable) begin
                        status_ff <= cpll_pkg::ST_FULL;
                     end else begin
                        if (tail_ff == cpll_pkg::NoneLink) head_ff <= count_ff;
                        tail_ff <= count_ff; res_ff <= count_ff;
                        if (tail_ff != cpll_pkg::NoneLink) begin
                           slot_ff <= tail_ff[SB-1:0];
                           n_ff <= cpll_pkg::NoneLink;
                           state_ff <= S_INS_W3;
                           op_ff <= cpll_pkg::OP_APPEND;
                        end else begin
                           count_ff <= count_ff + LB'(1);
                        end
                     end
                  end
                  cpll_pkg::OP_INSERT: begin
                     if (count_ff >= usable) status_ff <= cpll_pkg::ST_FULL;
                     else if (!occupied) status_ff <= cpll_pkg::ST_ABSENT;
                     else state_ff <= S_INS_RD;
                  end
                  cpll_pkg::OP_REMOVE: begin
                     if (count_ff == '0) status_ff <= cpll_pkg::ST_EMPTY;
                     else if (!occupied) status_ff <= cpll_pkg::ST_ABSENT;
                     else state_ff <= S_RM_RD;
                  end
                  cpll_pkg::OP_READ: begin
                     if (!occupied) status_ff <= cpll_pkg::ST_ABSENT;
                     else state_ff <= S_RD_WAIT;
                  end
                  cpll_pkg::OP_HEAD: res_ff <= head_ff;
                  cpll_pkg::OP_CLEAR: begin
                     count_ff <= '0; head_ff <= cpll_pkg::NoneLink;
                     tail_ff <= cpll_pkg::NoneLink;
                  end
                  default: ;
               endcase
            end
            S_INS_RD: begin
               n_ff <= mrsp.next;
               state_ff <= S_INS_W1;
            end
            S_INS_W1: begin
               state_ff <= S_INS_W2;
            end
            S_INS_W2: begin
               if (n_ff == cpll_pkg::NoneLink) tail_ff <= count_ff;
               state_ff <= S_INS_W3;
            end
            S_INS_W3: begin
               res_ff <= count_ff;
               count_ff <= count_ff + LB'(1);
               state_ff <= S_OUT;
            end
            S_RD_WAIT: begin
               res_ff <= {1'b0, slot_ff};
               dout_ff <= mrsp.data; pout_ff <= mrsp.prev; nout_ff <= mrsp.next;
               state_ff <= S_OUT;
            end
            S_RM_RD: state_ff <= S_RM_LRD;
            S_RM_LRD: begin
               p_ff <= mrsp.prev; n_ff <= mrsp.next; succ_ff <= mrsp.next;
               state_ff <= S_RM_LWAIT;
            end
            S_RM_LWAIT: begin
               mp_ff <= mrsp.prev; mn_ff <= mrsp.next; md_ff <= mrsp.data;
               state_ff <= S_RM_W1;
            end
            S_RM_W1: begin
               if (p_ff == cpll_pkg::NoneLink) head_ff <= n_ff;
               state_ff <= S_RM_W2;
            end
            S_RM_W2: begin
               if (n_ff == cpll_pkg::NoneLink) tail_ff <= p_ff;
               if (n_ff == last && n_ff != cpll_pkg::NoneLink) mp_ff <= p_ff;
               if (p_ff == last && p_ff != cpll_pkg::NoneLink) mn_ff <= n_ff;
               if ({1'b0, slot_ff} == last) begin
                  count_ff <= last; res_ff <= succ_ff; state_ff <= S_OUT;
               end else begin
                  state_ff <= S_RM_W3;
               end
            end
            S_RM_W3: begin
               if (mp_ff == cpll_pkg::NoneLink) head_ff <= {1'b0, slot_ff};
               state_ff <= S_RM_W4;
            end
            S_RM_W4: begin
               if (mn_ff == cpll_pkg::NoneLink) tail_ff <= {1'b0, slot_ff};
               state_ff <= S_RM_W5;
            end
            S_RM_W5: begin
               res_ff <= (succ_ff == last) ? {1'b0, slot_ff} : succ_ff;
               count_ff <= last;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= cpll_pkg::NoneLink)
      else $error("count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && state_ff == S_IDLE) |-> head_ff == cpll_pkg::NoneLink)
      else $error("empty list has a head");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready)
      else $error("transaction taken while result pending");
endmodule

// ===== hdl/cpll_node_mem.sv =====
`timescale 1ns / 1ps
module cpll_node_mem (
   input  logic                  clock,
   input  cpll_pkg::mem_cmd_type cmd,
   output cpll_pkg::mem_rsp_type rsp
);
   logic [cpll_pkg::LinkBits-1:0]  prev_mem [cpll_pkg::Capacity];
   logic [cpll_pkg::LinkBits-1:0]  next_mem [cpll_pkg::Capacity];
   logic [cpll_pkg::DataWidth-1:0] data_mem [cpll_pkg::Capacity];

   always_ff @(posedge clock) begin
      if (cmd.we && cmd.wprev_en) begin
         prev_mem[cmd.waddr] <= cmd.wprev;
      end
      if (cmd.we && cmd.wnext_en) begin
         next_mem[cmd.waddr] <= cmd.wnext;
      end
      if (cmd.we && cmd.wdata_en) begin
         data_mem[cmd.waddr] <= cmd.wdata;
      end
      rsp.prev <= prev_mem[cmd.raddr];
      rsp.next <= next_mem[cmd.raddr];
      rsp.data <= data_mem[cmd.raddr];
   end
endmodule

// ===== bench/compact_pool_linked_list_tb.sv =====
`timescale 1ns / 1ps
module compact_pool_linked_list_tb;
   import cpll_pkg::*;

   typedef struct packed {
      logic [1:0]           status;
      logic [LinkBits-1:0]  result_slot;
      logic [DataWidth-1:0] data_out;
      logic [LinkBits-1:0]  prev_slot;
      logic [LinkBits-1:0]  next_slot;
      logic [LinkBits-1:0]  count;
   } list_rsp_t;

   typedef struct {
      logic [2:0]           op;
      logic [SlotBits-1:0]  slot;
      logic [DataWidth-1:0] data;
      logic                 typed;
      list_rsp_t            rsp;
   } stim_row_t;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 20;

   logic clock = 1'b0;
   logic reset;
   cpll_req_if req ();
   cpll_rsp_if rsp ();
   cpll_csr_if csr ();

   compact_pool_linked_list dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   logic [LinkBits-1:0]  m_prev [Capacity];
   logic [LinkBits-1:0]  m_next [Capacity];
   logic [DataWidth-1:0] m_data [Capacity];
   logic [LinkBits-1:0]  m_head, m_tail, m_count, m_limit;

   list_rsp_t pending_rsp [$];
   int errors = 0;
   int cycles = 0;
   int hold_off = 0;
   bit rsp_random = 1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("compact_pool_linked_list_tb: errors");
         $finish;
      end
   end

   function automatic list_rsp_t list_apply(logic [2:0] op, logic [SlotBits-1:0] s,
                                            logic [DataWidth-1:0] d);
      list_rsp_t r;
      logic [LinkBits-1:0] p, n, nw, last, succ, mp, mn, lim;
      logic occ;
      r.status = ST_OK;
      r.result_slot = NoneLink;
      r.data_out = '0;
      r.prev_slot = NoneLink;
      r.next_slot = NoneLink;
      lim = (m_limit > Capacity) ? LinkBits'(Capacity) : m_limit;
      occ = {1'b0, s} < m_count;
      case (op)
         OP_APPEND: begin
            if (m_count >= lim) r.status = ST_FULL;
            else begin
               nw = m_count;
               m_prev[nw[SlotBits-1:0]] = m_tail;
               m_next[nw[SlotBits-1:0]] = NoneLink;
               m_data[nw[SlotBits-1:0]] = d;
               if (m_tail != NoneLink) m_next[m_tail[SlotBits-1:0]] = nw;
               else m_head = nw;
               m_tail = nw;
               m_count = nw + LinkBits'(1);
               r.result_slot = nw;
            end
         end
         OP_INSERT: begin
            if (m_count >= lim) r.status = ST_FULL;
            else if (!occ) r.status = ST_ABSENT;
            else begin
               nw = m_count;
               n = m_next[s];
               m_prev[nw[SlotBits-1:0]] = {1'b0, s};
               m_next[nw[SlotBits-1:0]] = n;
               m_data[nw[SlotBits-1:0]] = d;
               if (n != NoneLink) m_prev[n[SlotBits-1:0]] = nw;
               else m_tail = nw;
               m_next[s] = nw;
               m_count = nw + LinkBits'(1);
               r.result_slot = nw;
            end
         end
         OP_REMOVE: begin
            if (m_count == '0) r.status = ST_EMPTY;
            else if (!occ) r.status = ST_ABSENT;
            else begin
               p = m_prev[s];
               n = m_next[s];
               last = m_count - LinkBits'(1);
               succ = n;
               if (p != NoneLink) m_next[p[SlotBits-1:0]] = n;
               else m_head = n;
               if (n != NoneLink) m_prev[n[SlotBits-1:0]] = p;
               else m_tail = p;
               if ({1'b0, s} != last) begin
                  mp = m_prev[last[SlotBits-1:0]];
                  mn = m_next[last[SlotBits-1:0]];
                  m_prev[s] = mp;
                  m_next[s] = mn;
                  m_data[s] = m_data[last[SlotBits-1:0]];
                  if (mp != NoneLink) m_next[mp[SlotBits-1:0]] = {1'b0, s};
                  else m_head = {1'b0, s};
                  if (mn != NoneLink) m_prev[mn[SlotBits-1:0]] = {1'b0, s};
                  else m_tail = {1'b0, s};
                  if (succ == last) succ = {1'b0, s};
               end
               m_count = last;
               r.result_slot = succ;
            end
         end
         OP_READ: begin
            if (!occ) r.status = ST_ABSENT;
            else begin
               r.result_slot = {1'b0, s};
               r.data_out = m_data[s];
               r.prev_slot = m_prev[s];
               r.next_slot = m_next[s];
            end
         end
         OP_HEAD: r.result_slot = m_head;
         OP_CLEAR: begin
            m_count = '0;
            m_head = NoneLink;
            m_tail = NoneLink;
         end
         default: ;
      endcase
      r.count = m_count;
      return r;
   endfunction

   task automatic send_item(logic [2:0] op, logic [SlotBits-1:0] s, logic [DataWidth-1:0] d);
      req.valid <= 1;
      req.operation <= op;
      req.slot <= s;
      req.data <= d;
      do @(posedge clock); while (!req.ready);
      pending_rsp.push_back(list_apply(op, s, d));
   endtask

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) g = 0;
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_limit(logic [LinkBits-1:0] v);
      csr.valid <= 1;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      m_limit = v;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction: %h",
               {rsp.status, rsp.result_slot, rsp.data_out, rsp.prev_slot, rsp.next_slot,
                rsp.count});
         end else begin
            list_rsp_t e;
            e = pending_rsp.pop_front();
            if (e.status !== rsp.status || e.result_slot !== rsp.result_slot ||
                e.data_out !== rsp.data_out || e.prev_slot !== rsp.prev_slot ||
                e.next_slot !== rsp.next_slot || e.count !== rsp.count) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp %0d %0d %h %0d %0d %0d act %0d %0d %h %0d %0d %0d",
                     e.status, e.result_slot, e.data_out, e.prev_slot, e.next_slot, e.count,
                     rsp.status, rsp.result_slot, rsp.data_out, rsp.prev_slot,
                     rsp.next_slot, rsp.count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 0;
      end else if (!rsp_random) rsp.ready <= 1;
      else if ($urandom_range(0, 19) == 0) hold_off <= $urandom_range(8, 30);
      else rsp.ready <= ($urandom_range(0, 3) != 0);
   end

   function automatic list_rsp_t mk(logic [1:0] st, logic [LinkBits-1:0] rs,
                                    logic [LinkBits-1:0] c);
      list_rsp_t r;
      r.status = st;
      r.result_slot = rs;
      r.data_out = '0;
      r.prev_slot = NoneLink;
      r.next_slot = NoneLink;
      r.count = c;
      return r;
   endfunction

   function automatic stim_row_t row(logic [2:0] op, logic [SlotBits-1:0] s,
                                     logic [DataWidth-1:0] d, logic typed, list_rsp_t r);
      stim_row_t x;
      x.op = op;
      x.slot = s;
      x.data = d;
      x.typed = typed;
      x.rsp = r;
      return x;
   endfunction

   task automatic random_items(int n, int max_len);
      logic [2:0] op;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 35) op = OP_APPEND;
         else if (k < 55) op = OP_INSERT;
         else if (k < 75) op = OP_REMOVE;
         else if (k < 90) op = OP_READ;
         else if (k < 95) op = OP_HEAD;
         else if (k < 97) op = OP_CLEAR;
         else op = 3'($urandom_range(6, 7));
         if (m_count >= max_len && op inside {OP_APPEND, OP_INSERT} && k % 2 == 0)
            op = OP_REMOVE;
         send_item(op, ($urandom_range(0, 9) == 0 || m_count == 0) ? 8'($urandom) :
                   8'($urandom_range(0, m_count - 1)), $urandom);
         idle_gap();
      end
   endtask

   initial begin
      stim_row_t rows [$];
      list_rsp_t got;
      reset = 1;
      req.valid = 0;
      req.operation = '0;
      req.slot = '0;
      req.data = '0;
      csr.valid = 0;
      csr.data = '0;
      m_head = NoneLink;
      m_tail = NoneLink;
      m_count = 0;
      m_limit = 256;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      rows.push_back(row(OP_HEAD, 0, 0, 1, mk(ST_OK, NoneLink, 0)));
      rows.push_back(row(OP_REMOVE, 0, 0, 1, mk(ST_EMPTY, NoneLink, 0)));
      rows.push_back(row(OP_READ, 0, 0, 1, mk(ST_ABSENT, NoneLink, 0)));
      rows.push_back(row(OP_INSERT, 255, 0, 1, mk(ST_ABSENT, NoneLink, 0)));
      rows.push_back(row(OP_APPEND, 0, 32'hFFFFFFFF, 1, mk(ST_OK, 0, 1)));
      rows.push_back(row(OP_APPEND, 255, 32'h0, 1, mk(ST_OK, 1, 2)));
      rows.push_back(row(OP_INSERT, 0, 32'hA5A5A5A5, 1, mk(ST_OK, 2, 3)));
      rows.push_back(row(OP_READ, 0, 0, 0, got));
      rows.push_back(row(OP_READ, 2, 0, 0, got));
      rows.push_back(row(OP_READ, 3, 0, 1, mk(ST_ABSENT, NoneLink, 3)));
      rows.push_back(row(OP_INSERT, 1, 32'h12345678, 0, got));
      rows.push_back(row(OP_REMOVE, 2, 0, 0, got));
      rows.push_back(row(OP_REMOVE, 0, 0, 0, got));
      rows.push_back(row(OP_HEAD, 0, 0, 0, got));
      rows.push_back(row(OP_REMOVE, 1, 0, 0, got));
      rows.push_back(row(3'd6, 0, 0, 0, got));
      rows.push_back(row(3'd7, 255, 32'hFFFFFFFF, 0, got));
      rows.push_back(row(OP_CLEAR, 0, 0, 1, mk(ST_OK, NoneLink, 0)));
      rows.push_back(row(OP_HEAD, 0, 0, 1, mk(ST_OK, NoneLink, 0)));
      foreach (rows[i]) begin
         send_item(rows[i].op, rows[i].slot, rows[i].data);
         if (rows[i].typed) pending_rsp[$] = rows[i].rsp;
         idle_gap();
      end
      drain();

      write_limit(0);
      send_item(OP_APPEND, 0, 1);
      pending_rsp[$] = mk(ST_FULL, NoneLink, 0);
      send_item(OP_INSERT, 0, 1);
      pending_rsp[$] = mk(ST_FULL, NoneLink, 0);
      drain();

      write_limit(1);
      send_item(OP_APPEND, 0, 7);
      send_item(OP_APPEND, 0, 8);
      pending_rsp[$] = mk(ST_FULL, NoneLink, 1);
      send_item(OP_REMOVE, 0, 0);
      random_items(10, 4);
      drain();

      write_limit(511);
      random_items(20, 16);
      hold_off = 300;
      random_items(20, 16);
      drain();

      write_limit(5);
      random_items(30, 8);
      drain();

      write_limit(256);
      rsp_random = 0;
      for (int i = 0; i < 256; i++) send_item(OP_APPEND, 0, $urandom);
      send_item(OP_APPEND, 0, 0);
      pending_rsp[$] = mk(ST_FULL, NoneLink, 256);
      send_item(OP_INSERT, 0, 0);
      pending_rsp[$] = mk(ST_FULL, NoneLink, 256);
      send_item(OP_READ, 255, 0);
      send_item(OP_REMOVE, 255, 0);
      send_item(OP_REMOVE, 0, 0);
      rsp_random = 1;
      random_items(20, 256);
      drain();

      write_limit(12);
      send_item(OP_CLEAR, 0, 0);
      random_items(20, 12);
      drain();

      if (errors == 0) $display("compact_pool_linked_list_tb: clean");
      else $display("compact_pool_linked_list_tb: errors");
      $finish;
   end
endmodule

// ===== compact_pool_linked_list.f =====
hdl/cpll_pkg.sv
hdl/cpll_req_if.sv
hdl/cpll_rsp_if.sv
hdl/cpll_csr_if.sv
hdl/cpll_node_mem.sv
hdl/compact_pool_linked_list.sv
bench/compact_pool_linked_list_tb.sv
